[sv/pse_pkg.sv]
// shared constants, status codes and controller/datapath interface structs
// for the postfix stack evaluator; no dependencies
package pse_pkg;

	localparam int DefStackDepth = 16;
	localparam int DefValueWidth = 32;
	localparam int OutWidth      = 32;
	localparam int MulChunk      = 16;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChPlus  = 8'h2B;
	localparam logic [7:0] ChMinus = 8'h2D;
	localparam logic [7:0] ChStar  = 8'h2A;
	localparam logic [7:0] ChSlash = 8'h2F;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_DIVZERO   = 2'd3
	} status_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic op_mul;
		logic op_div;
		logic last;
		logic mul_done;
		logic div_done;
	} sts_t;

endpackage

[sv/pse_mul.sv]
// iterative multiplier, low product bits only, one chunk of b per cycle
// depends on pse_pkg
module pse_mul #(
	parameter int W = pse_pkg::DefValueWidth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] product
);

	localparam int CH   = (W < pse_pkg::MulChunk) ? W : pse_pkg::MulChunk;
	localparam int NCH  = (W + CH - 1) / CH;
	localparam int CNTW = $clog2(NCH + 2);

	logic [W-1:0]    a_q, b_q, acc_q, pp_s1;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [W+CH-1:0] prod_full;

	assign prod_full = (W+CH)'(a_q) * (W+CH)'(b_q[CH-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(NCH + 1);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial product registered, accumulated in the following cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
			pp_s1 <= '0;
		end else if (cnt_q != '0) begin
			pp_s1 <= prod_full[W-1:0];
			a_q   <= a_q << CH;
			b_q   <= b_q >> CH;
			acc_q <= acc_q + pp_s1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

[sv/pse_div.sv]
// signed restoring divider, quotient truncated toward zero, one bit per cycle
// depends on pse_pkg
module pse_div #(
	parameter int W = pse_pkg::DefValueWidth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] quot
);

	localparam int CNTW = $clog2(W + 1);

	logic [W-1:0]    q_q, d_q, r_q;
	logic            neg_q;
	logic [CNTW-1:0] cnt_q;
	logic            done_q;
	logic [W-1:0]    a_mag, b_mag;
	logic [W:0]      shifted;
	logic [W+1:0]    trial;

	assign a_mag   = a[W-1] ? (~a + W'(1)) : a;
	assign b_mag   = b[W-1] ? (~b + W'(1)) : b;
	assign shifted = {r_q, q_q[W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= a_mag;
			d_q   <= b_mag;
			r_q   <= '0;
			neg_q <= a[W-1] ^ b[W-1];
		end else if (cnt_q != '0) begin
			if (!trial[W+1]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= shifted[W-1:0];
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = neg_q ? (~q_q + W'(1)) : q_q;

endmodule

[sv/pse_dpath.sv]
// datapath: operand stack memory, count, sticky error, alu, result register
// depends on pse_pkg, pse_mul, pse_div
module pse_dpath #(
	parameter int Depth = pse_pkg::DefStackDepth,
	parameter int W     = pse_pkg::DefValueWidth
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [7:0]                           symbol,
	input  logic                                 last,
	input  pse_pkg::cmd_t                        cmd,
	output pse_pkg::sts_t                        sts,
	output logic signed [pse_pkg::OutWidth-1:0]  value,
	output logic [1:0]                           status
);

	localparam int IW = $clog2(Depth);
	localparam int CW = $clog2(Depth + 1);
	localparam int OW = pse_pkg::OutWidth;

	logic [W-1:0]           mem [Depth];
	logic [7:0]             sym_q;
	logic                   last_q;
	logic [W-1:0]           rd1_q, rd2_q;
	logic [CW-1:0]          cnt_q, cnt_d;
	pse_pkg::status_t       err_q, err_d, err_new, fin_status;
	logic signed [OW-1:0]   value_q;
	pse_pkg::status_t       status_q;

	logic [CW-1:0]          cnt_m1, cnt_m2, pop_cnt;
	logic                   is_digit, have_r, have_l, room, div_zero, op_mul, op_slash;
	logic [W-1:0]           digit_val, right, left;
	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	logic [W-1:0]           wr_data;
	logic                   mul_start, div_start, mul_done, div_done;
	logic [W-1:0]           product, quot;

	assign is_digit  = (sym_q >= pse_pkg::ChZero) && (sym_q <= pse_pkg::ChNine);
	assign digit_val = W'(sym_q - pse_pkg::ChZero);
	assign cnt_m1    = cnt_q - CW'(1);
	assign cnt_m2    = cnt_q - CW'(2);
	assign have_r    = cnt_q != '0;
	assign have_l    = cnt_q > CW'(1);
	assign right     = have_r ? rd1_q : '0;
	assign left      = have_l ? rd2_q : '0;
	assign pop_cnt   = have_l ? cnt_m2 : '0;
	assign room      = cnt_q < CW'(Depth);
	assign div_zero  = right == '0;
	assign op_mul    = sym_q == pse_pkg::ChStar;
	assign op_slash  = sym_q == pse_pkg::ChSlash;

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = cnt_q[IW-1:0];
		wr_data   = digit_val;
		cnt_d     = cnt_q;
		err_new   = pse_pkg::ST_OK;
		mul_start = 1'b0;
		div_start = 1'b0;
		if (cmd.exec) begin
			if (is_digit) begin
				if (room) begin
					wr_en = 1'b1;
					cnt_d = cnt_q + CW'(1);
				end else begin
					err_new = pse_pkg::ST_OVERFLOW;
				end
			end else begin
				cnt_d   = pop_cnt;
				wr_addr = pop_cnt[IW-1:0];
				if (!have_l) begin
					err_new = pse_pkg::ST_UNDERFLOW;
				end
				unique case (sym_q)
					pse_pkg::ChPlus: begin
						wr_en   = 1'b1;
						wr_data = left + right;
						cnt_d   = pop_cnt + CW'(1);
					end
					pse_pkg::ChMinus: begin
						wr_en   = 1'b1;
						wr_data = left - right;
						cnt_d   = pop_cnt + CW'(1);
					end
					pse_pkg::ChStar: begin
						mul_start = 1'b1;
					end
					pse_pkg::ChSlash: begin
						if (div_zero) begin
							wr_en   = 1'b1;
							wr_data = '0;
							cnt_d   = pop_cnt + CW'(1);
							if (have_l) begin
								err_new = pse_pkg::ST_DIVZERO;
							end
						end else begin
							div_start = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end else if (mul_done) begin
			wr_en   = 1'b1;
			wr_data = product;
			cnt_d   = cnt_q + CW'(1);
		end else if (div_done) begin
			wr_en   = 1'b1;
			wr_data = quot;
			cnt_d   = cnt_q + CW'(1);
		end else if (cmd.finish) begin
			cnt_d = '0;
		end
	end

	// first error sticks until the expression ends
	always_comb begin
		err_d = err_q;
		if (cmd.finish) begin
			err_d = pse_pkg::ST_OK;
		end else if (err_q == pse_pkg::ST_OK) begin
			err_d = err_new;
		end
	end

	assign fin_status = (err_q != pse_pkg::ST_OK) ? err_q :
		(have_r ? pse_pkg::ST_OK : pse_pkg::ST_UNDERFLOW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= pse_pkg::ST_OK;
		end else begin
			cnt_q <= cnt_d;
			err_q <= err_d;
		end
	end

	// stack memory, two registered reads at the top two entries
	always_ff @(posedge clk) begin
		rd1_q <= mem[cnt_m1[IW-1:0]];
		rd2_q <= mem[cnt_m2[IW-1:0]];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sym_q  <= symbol;
			last_q <= last;
		end
		if (cmd.finish) begin
			value_q  <= OW'($signed(right));
			status_q <= fin_status;
		end
	end

	pse_mul #(.W(W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (left),
		.b       (right),
		.done    (mul_done),
		.product (product)
	);

	pse_div #(.W(W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (left),
		.b      (right),
		.done   (div_done),
		.quot   (quot)
	);

	assign sts.op_mul   = op_mul;
	assign sts.op_div   = op_slash && !div_zero;
	assign sts.last     = last_q;
	assign sts.mul_done = mul_done;
	assign sts.div_done = div_done;
	assign value        = value_q;
	assign status       = status_q;

	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(Depth))
		else $error("stack count beyond depth");

	ap_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (cnt_q == '0) && (err_q == pse_pkg::ST_OK))
		else $error("stack or error not cleared after result");

	ap_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && is_digit && !room) |=> (cnt_q == $past(cnt_q)) && (err_q != pse_pkg::ST_OK))
		else $error("push onto full stack not dropped");

endmodule

[sv/pse_ctrl.sv]
// controller state machine: handshakes, sequencing, output valid
// depends on pse_pkg
module pse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sym_valid,
	output logic          sym_stall,
	output logic          res_valid,
	input  logic          res_stall,
	output pse_pkg::cmd_t cmd,
	input  pse_pkg::sts_t sts
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_EXEC   = 6'b000010,
		S_MULW   = 6'b000100,
		S_DIVW   = 6'b001000,
		S_SETTLE = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   valid_q;
	logic   out_free;

	assign out_free   = !valid_q || !res_stall;
	assign sym_stall  = state_q != S_IDLE;
	assign cmd.accept = (state_q == S_IDLE) && sym_valid;
	assign cmd.exec   = state_q == S_EXEC;
	assign cmd.finish = (state_q == S_FINISH) && out_free;
	assign res_valid  = valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (sym_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (sts.op_mul) state_d = S_MULW;
				else if (sts.op_div) state_d = S_DIVW;
				else if (sts.last) state_d = S_SETTLE;
				else state_d = S_IDLE;
			end
			S_MULW: begin
				if (sts.mul_done) state_d = sts.last ? S_SETTLE : S_IDLE;
			end
			S_DIVW: begin
				if (sts.div_done) state_d = sts.last ? S_SETTLE : S_IDLE;
			end
			S_SETTLE: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				valid_q <= 1'b1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	ap_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.mul_done |-> state_q == S_MULW)
		else $error("multiplier finished outside its wait state");

	ap_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> state_q == S_DIVW)
		else $error("divider finished outside its wait state");

	ap_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(sym_valid && !sym_stall) |=> state_q == S_EXEC)
		else $error("accepted item not executed");

endmodule

[sv/postfix_stack_evaluator_core.sv]
// top level of the postfix stack evaluator: controller plus datapath
// depends on pse_pkg, pse_ctrl, pse_dpath (which holds pse_mul, pse_div)
//
// Evaluates a postfix expression fed one character per item. A digit pushes
// its value; '+', '-', '*' and '/' pop two operands (right first) and push the
// wrapped result, '/' truncating toward zero; any other character just pops
// two. The item marked last ends the expression: its result item carries the
// popped top value (sign-extended or cut to 32 bits) and the first error seen
// (underflow, overflow, divide by zero), then stack and error clear. Each item
// is accepted, then executed once the registered read of the stack memory
// has fetched the operands. '*' then runs in the chunked multiplier and '/' in
// the bit-serial divider, unless the divisor is zero and 0 is pushed directly.
// The last item of an expression then refetches the top of stack and loads
// the result register, held up while an earlier result still waits in that
// register. The stack needs no clearing after reset.
module postfix_stack_evaluator_core #(
	parameter int STACK_DEPTH = pse_pkg::DefStackDepth,
	parameter int VALUE_WIDTH = pse_pkg::DefValueWidth
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// expression characters
	input  logic [7:0]                          symbol,
	input  logic                                last,
	input  logic                                sym_valid,
	output logic                                sym_stall,
	// one result item per expression
	output logic signed [pse_pkg::OutWidth-1:0] value,
	output logic [1:0]                          status,
	output logic                                res_valid,
	input  logic                                res_stall
);

	// commands from the sequencer, status back from the datapath
	pse_pkg::cmd_t cmd;
	pse_pkg::sts_t sts;

	pse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_stall (sym_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// stack memory, alu and iterative units, result register
	pse_dpath #(
		.Depth (STACK_DEPTH),
		.W     (VALUE_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.symbol (symbol),
		.last   (last),
		.cmd    (cmd),
		.sts    (sts),
		.value  (value),
		.status (status)
	);

endmodule
